// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the checker file dq_chk.sv
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define DQ_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define DQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- hw/rtl/dq_pkg.sv -----
// ----------------------------------------------------------------------------
// dq_pkg
// Field widths, operation codes and status codes of the ring deque.
// ----------------------------------------------------------------------------
package dq_pkg;

	localparam int OP_W        = 4;
	localparam int VALUE_W     = 32;
	localparam int INDEX_W     = 7;
	localparam int DATA_PORT_W = 32;
	localparam int COUNT_W     = 7;
	localparam int STATUS_W    = 2;

	localparam logic [OP_W-1:0] OP_PUSH_BACK  = 4'd0;
	localparam logic [OP_W-1:0] OP_PUSH_FRONT = 4'd1;
	localparam logic [OP_W-1:0] OP_POP_BACK   = 4'd2;
	localparam logic [OP_W-1:0] OP_POP_FRONT  = 4'd3;
	localparam logic [OP_W-1:0] OP_READ       = 4'd4;
	localparam logic [OP_W-1:0] OP_WRITE      = 4'd5;
	localparam logic [OP_W-1:0] OP_INSERT     = 4'd6;
	localparam logic [OP_W-1:0] OP_ERASE      = 4'd7;
	localparam logic [OP_W-1:0] OP_CLEAR      = 4'd8;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

endpackage

// ----- hw/rtl/dq_if.sv -----
// ----------------------------------------------------------------------------
// dq_req_if / dq_rsp_if
// Valid/ready channels for deque requests and their results.
// ----------------------------------------------------------------------------
interface dq_req_if;
	import dq_pkg::*;

	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    op;
	logic [VALUE_W-1:0] value;
	logic [INDEX_W-1:0] index;

	modport source (output valid, op, value, index, input ready);
	modport sink   (input valid, op, value, index, output ready);
endinterface

interface dq_rsp_if;
	import dq_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [DATA_PORT_W-1:0] data;
	logic [COUNT_W-1:0]     count;
	logic [STATUS_W-1:0]    status;

	modport source (output valid, data, count, status, input ready);
	modport sink   (input valid, data, count, status, output ready);
endinterface

// ----- hw/rtl/dq_slot_unit.sv -----
// ----------------------------------------------------------------------------
// dq_slot_unit
// Shared ring address unit: physical slot of a logical position.
// ----------------------------------------------------------------------------
module dq_slot_unit #(
	parameter int DEPTH = 64
) (
	input  logic [$clog2(DEPTH)-1:0]   head,
	input  logic [$clog2(DEPTH+1)-1:0] logical,
	output logic [$clog2(DEPTH)-1:0]   slot
);
	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);

	logic [CW:0] sum;
	logic [CW:0] wrapped;

	// head < DEPTH and logical <= DEPTH, so one subtract folds the sum back
	assign sum     = (CW+1)'(head) + (CW+1)'(logical);
	assign wrapped = (sum >= (CW+1)'(DEPTH)) ? (sum - (CW+1)'(DEPTH)) : sum;
	assign slot    = wrapped[AW-1:0];

endmodule

// ----- hw/rtl/dq_ram.sv -----
// ----------------------------------------------------------------------------
// dq_ram
// Single-port ring storage with registered read data.
// ----------------------------------------------------------------------------
module dq_ram #(
	parameter int DEPTH  = 64,
	parameter int DATA_W = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [DATA_W-1:0]        wdata,
	output logic [DATA_W-1:0]        rdata
);
	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/double_ended_queue_ring_core.sv -----
// ----------------------------------------------------------------------------
// double_ended_queue_ring_core: a request passes S_EXEC (and S_RDW for pops and reads) to
// S_DONE, where the result waits for the output register. Insert and erase move each element
// by a read (S_SHRD) and a write (S_SHWR) on the single RAM port; insert ends in S_FILL.
// Ready returns as the result registers. Async reset clears head, count, control, not storage.
// ----------------------------------------------------------------------------
module double_ended_queue_ring_core #(
	parameter int DEPTH  = 64,
	parameter int DATA_W = 32
) (
	input  logic      clk,
	input  logic      arst_n,
	dq_req_if.sink    req,
	dq_rsp_if.source  rsp
);
	import dq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);
	localparam int IW = (CW > INDEX_W) ? CW : INDEX_W;
	localparam int VW = (DATA_W > DATA_PORT_W) ? DATA_W : DATA_PORT_W;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_EXEC = 7'b0000010,
		S_RDW  = 7'b0000100,
		S_SHRD = 7'b0001000,
		S_SHWR = 7'b0010000,
		S_FILL = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t                 state_q;
	logic [AW-1:0]          head_q;
	logic [CW-1:0]          count_q;
	logic [OP_W-1:0]        op_q;
	logic [DATA_W-1:0]      value_q;
	logic [IW-1:0]          idx_q;
	logic [CW-1:0]          k_q;
	logic [DATA_W-1:0]      data_q;
	status_t                status_q;
	logic                   rsp_valid_q;
	logic [DATA_PORT_W-1:0] rsp_data_q;
	logic [COUNT_W-1:0]     rsp_count_q;
	logic [STATUS_W-1:0]    rsp_status_q;

	logic [CW-1:0]     slot_logical;
	logic [AW-1:0]     slot_addr;
	logic              mem_we;
	logic              mem_re;
	logic [DATA_W-1:0] mem_wdata;
	logic [DATA_W-1:0] mem_rdata;
	logic [VW-1:0]     value_ext;
	logic [VW-1:0]     data_ext;
	logic [CW-1:0]     idx_c;
	logic [CW-1:0]     k_next;
	logic              ins;
	logic              full;
	logic              empty;
	logic              range_rd;
	logic              range_ins;
	logic              rsp_load;

	dq_slot_unit #(.DEPTH(DEPTH)) u_slot (
		.head    (head_q),
		.logical (slot_logical),
		.slot    (slot_addr)
	);

	dq_ram #(.DEPTH(DEPTH), .DATA_W(DATA_W)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (slot_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	assign value_ext = VW'(req.value);
	assign data_ext  = VW'(data_q);
	assign idx_c     = idx_q[CW-1:0];
	assign ins       = (op_q == OP_INSERT);
	assign k_next    = ins ? (k_q - CW'(1)) : (k_q + CW'(1));
	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign range_rd  = (idx_q >= IW'(count_q));
	assign range_ins = (idx_q > IW'(count_q));
	// hold the result until the output register frees up
	assign rsp_load  = (state_q == S_DONE) && (!rsp_valid_q || rsp.ready);

	always_comb begin
		slot_logical = '0;
		mem_we       = 1'b0;
		mem_re       = 1'b0;
		mem_wdata    = value_q;
		case (state_q)
			S_EXEC: begin
				case (op_q)
					OP_PUSH_BACK: begin
						slot_logical = count_q;
						mem_we       = !full;
					end
					OP_PUSH_FRONT: begin
						slot_logical = CW'(DEPTH - 1);
						mem_we       = !full;
					end
					OP_POP_BACK: begin
						slot_logical = count_q - CW'(1);
						mem_re       = !empty;
					end
					OP_POP_FRONT: begin
						mem_re = !empty;
					end
					OP_READ: begin
						slot_logical = idx_c;
						mem_re       = !range_rd;
					end
					OP_WRITE: begin
						slot_logical = idx_c;
						mem_we       = !range_rd;
					end
					default: ;
				endcase
			end
			// new head after a pop at the front
			S_RDW: slot_logical = CW'(1);
			S_SHRD: begin
				slot_logical = k_next;
				mem_re       = 1'b1;
			end
			S_SHWR: begin
				slot_logical = k_q;
				mem_we       = 1'b1;
				mem_wdata    = mem_rdata;
			end
			S_FILL: begin
				slot_logical = idx_c;
				mem_we       = 1'b1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= '0;
			count_q      <= '0;
			op_q         <= '0;
			value_q      <= '0;
			idx_q        <= '0;
			k_q          <= '0;
			data_q       <= '0;
			status_q     <= ST_OK;
			rsp_valid_q  <= 1'b0;
			rsp_data_q   <= '0;
			rsp_count_q  <= '0;
			rsp_status_q <= '0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						op_q     <= req.op;
						value_q  <= value_ext[DATA_W-1:0];
						idx_q    <= IW'(req.index);
						data_q   <= '0;
						status_q <= ST_OK;
						state_q  <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_DONE;
					case (op_q)
						OP_PUSH_BACK: begin
							if (full) status_q <= ST_FULL;
							else count_q <= count_q + CW'(1);
						end
						OP_PUSH_FRONT: begin
							if (full) begin
								status_q <= ST_FULL;
							end else begin
								head_q  <= slot_addr;
								count_q <= count_q + CW'(1);
							end
						end
						OP_POP_BACK, OP_POP_FRONT: begin
							if (empty) begin
								status_q <= ST_EMPTY;
							end else begin
								count_q <= count_q - CW'(1);
								state_q <= S_RDW;
							end
						end
						OP_READ: begin
							if (range_rd) status_q <= ST_RANGE;
							else state_q <= S_RDW;
						end
						OP_WRITE: begin
							if (range_rd) status_q <= ST_RANGE;
						end
						OP_INSERT: begin
							if (range_ins) begin
								status_q <= ST_RANGE;
							end else if (full) begin
								status_q <= ST_FULL;
							end else if (idx_c == count_q) begin
								state_q <= S_FILL;
							end else begin
								k_q     <= count_q;
								state_q <= S_SHRD;
							end
						end
						OP_ERASE: begin
							if (range_rd) begin
								status_q <= ST_RANGE;
							end else if ((idx_c + CW'(1)) < count_q) begin
								k_q     <= idx_c;
								state_q <= S_SHRD;
							end else begin
								count_q <= count_q - CW'(1);
							end
						end
						OP_CLEAR: begin
							head_q  <= '0;
							count_q <= '0;
						end
						default: ;
					endcase
				end
				S_RDW: begin
					data_q <= mem_rdata;
					if (op_q == OP_POP_FRONT) begin
						head_q <= slot_addr;
					end
					state_q <= S_DONE;
				end
				S_SHRD: state_q <= S_SHWR;
				S_SHWR: begin
					k_q <= k_next;
					if (ins) begin
						state_q <= (k_next == idx_c) ? S_FILL : S_SHRD;
					end else if ((k_next + CW'(1)) < count_q) begin
						state_q <= S_SHRD;
					end else begin
						count_q <= count_q - CW'(1);
						state_q <= S_DONE;
					end
				end
				S_FILL: begin
					count_q <= count_q + CW'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (rsp_load) begin
						rsp_data_q   <= data_ext[DATA_PORT_W-1:0];
						rsp_count_q  <= COUNT_W'(count_q);
						rsp_status_q <= status_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req.ready  = (state_q == S_IDLE);
	assign rsp.valid  = rsp_valid_q;
	assign rsp.data   = rsp_data_q;
	assign rsp.count  = rsp_count_q;
	assign rsp.status = rsp_status_q;

endmodule

// ----- hw/rtl/dq_chk.sv -----
// ----------------------------------------------------------------------------
// dq_chk
// Port-level checks of the ring deque, bound to double_ended_queue_ring_core.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dq_chk #(
	parameter int DEPTH = 64
) (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           req_valid,
	input logic                           req_ready,
	input logic                           rsp_valid,
	input logic                           rsp_ready,
	input logic [dq_pkg::DATA_PORT_W-1:0] rsp_data,
	input logic [dq_pkg::COUNT_W-1:0]     rsp_count,
	input logic [dq_pkg::STATUS_W-1:0]    rsp_status
);
	import dq_pkg::*;

	// refused requests (status not OK) return no data
	`DQ_ASSERT_NOW(a_refused_no_data, clk, arst_n, rsp_valid && (rsp_status != ST_OK), rsp_data == '0)
	`DQ_ASSERT_NOW(a_empty_count, clk, arst_n, rsp_valid && (rsp_status == ST_EMPTY), rsp_count == '0)
	`DQ_ASSERT_NOW(a_count_bound, clk, arst_n, rsp_valid, int'(rsp_count) <= DEPTH)
	// one request in flight at a time
	`DQ_ASSERT_NEXT(a_one_in_flight, clk, arst_n, req_valid && req_ready, !req_ready)
	`DQ_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data) && $stable(rsp_count) && $stable(rsp_status))

endmodule

bind double_ended_queue_ring_core dq_chk #(.DEPTH(DEPTH)) u_dq_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_data   (rsp.data),
	.rsp_count  (rsp.count),
	.rsp_status (rsp.status)
);

// ----- tb/deque_shadow_pkg.sv -----
// ----------------------------------------------------------------------------
// deque_shadow_pkg
// Shadow copy of the ring deque for the testbench: it applies each accepted
// request to its own ring, head and fill, and queues the result the block
// has to return for it.
// ----------------------------------------------------------------------------
package deque_shadow_pkg;
	import dq_pkg::*;

	localparam int DEPTH  = 64;
	localparam int DATA_W = 32;

	// op codes the block has no meaning for
	localparam logic [OP_W-1:0] OP_UNUSED_LO = 4'd9;
	localparam logic [OP_W-1:0] OP_UNUSED_HI = 4'd15;

	typedef enum int {
		MODE_FILL,
		MODE_DRAIN,
		MODE_MIX
	} load_mode_t;

	typedef struct packed {
		logic [DATA_PORT_W-1:0] data;
		logic [COUNT_W-1:0]     count;
		status_t                status;
	} deque_result_t;

	class deque_shadow;
		logic [DATA_W-1:0] ring [DEPTH];
		int                head;
		int                fill;
		deque_result_t     due_results [$];

		function new();
			head = 0;
			fill = 0;
		endfunction

		function int slot(int k);
			return (head + k) % DEPTH;
		endfunction

		function int pending();
			return due_results.size();
		endfunction

		function void note_request(logic [OP_W-1:0] op, logic [VALUE_W-1:0] value,
				logic [INDEX_W-1:0] index);
			deque_result_t res;
			int idx;
			int k;
			res.data   = '0;
			res.status = ST_OK;
			idx        = int'(index);
			case (op)
			OP_PUSH_BACK: begin
				if (fill >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					ring[slot(fill)] = value[DATA_W-1:0];
					fill++;
				end
			end
			OP_PUSH_FRONT: begin
				if (fill >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					head       = (head + DEPTH - 1) % DEPTH;
					ring[head] = value[DATA_W-1:0];
					fill++;
				end
			end
			OP_POP_BACK: begin
				if (fill == 0) begin
					res.status = ST_EMPTY;
				end else begin
					res.data = ring[slot(fill - 1)];
					fill--;
				end
			end
			OP_POP_FRONT: begin
				if (fill == 0) begin
					res.status = ST_EMPTY;
				end else begin
					res.data = ring[head];
					head     = slot(1);
					fill--;
				end
			end
			OP_READ: begin
				if (idx >= fill) res.status = ST_RANGE;
				else res.data = ring[slot(idx)];
			end
			OP_WRITE: begin
				if (idx >= fill) res.status = ST_RANGE;
				else ring[slot(idx)] = value[DATA_W-1:0];
			end
			OP_INSERT: begin
				// range test wins over the full test
				if (idx > fill) begin
					res.status = ST_RANGE;
				end else if (fill >= DEPTH) begin
					res.status = ST_FULL;
				end else begin
					for (k = fill; k > idx; k--)
						ring[slot(k)] = ring[slot(k - 1)];
					ring[slot(idx)] = value[DATA_W-1:0];
					fill++;
				end
			end
			OP_ERASE: begin
				if (idx >= fill) begin
					res.status = ST_RANGE;
				end else begin
					for (k = idx; k + 1 < fill; k++)
						ring[slot(k)] = ring[slot(k + 1)];
					fill--;
				end
			end
			OP_CLEAR: begin
				head = 0;
				fill = 0;
			end
			default: ;
			endcase
			res.count = fill[COUNT_W-1:0];
			due_results.insert(due_results.size(), res);
		endfunction

		// Empty string when the result matches the oldest expectation.
		function string check_result(logic [DATA_PORT_W-1:0] data, logic [COUNT_W-1:0] count,
				logic [STATUS_W-1:0] status);
			deque_result_t want;
			if (due_results.size() == 0)
				return $sformatf("unexpected result: data %h count %0d status %0d",
					data, count, status);
			want = due_results[0];
			due_results.delete(0);
			if (data !== want.data || count !== want.count || status !== want.status)
				return $sformatf("result mismatch (got/want): data %h/%h count %0d/%0d status %0d/%0d",
					data, want.data, count, want.count, status, want.status);
			return "";
		endfunction
	endclass

endpackage

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Drives requests into double_ended_queue_ring_core: a directed sequence over
// empty, wrap, boundary and unused-code cases, then phases biased toward
// filling, draining or mixed traffic. Every result is compared with the
// shadow deque while both channels idle at random.
// ----------------------------------------------------------------------------
module tb;
	import dq_pkg::*;
	import deque_shadow_pkg::*;

	localparam int RANDOM_ITEMS = 500;
	localparam int DRAIN_CYCLES = 300;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int MAX_LINES    = 40;

	logic clk = 1'b0;
	logic arst_n;

	int          error_count = 0;
	int          cycle_count = 0;
	bit          send_quiet  = 1'b0;
	deque_shadow book;

	dq_req_if req_ch ();
	dq_rsp_if rsp_ch ();

	double_ended_queue_ring_core #(
		.DEPTH  (DEPTH),
		.DATA_W (DATA_W)
	) u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		if (error_count < MAX_LINES)
			$display("cycle %0d: %s", cycle_count, msg);
		error_count++;
	endtask

	task automatic send_request(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] value,
			input logic [INDEX_W-1:0] index);
		int gap;
		gap = send_quiet ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op    <= op;
		req_ch.value <= value;
		req_ch.index <= index;
		do @(posedge clk); while (!req_ch.ready);
		book.note_request(op, value, index);
	endtask

	function automatic logic [OP_W-1:0] pick_op(load_mode_t mode);
		int r;
		r = $urandom_range(0, 99);
		case (mode)
		MODE_FILL: begin
			if (r < 30) return OP_PUSH_BACK;
			if (r < 55) return OP_PUSH_FRONT;
			if (r < 75) return OP_INSERT;
			if (r < 85) return OP_READ;
			if (r < 90) return OP_WRITE;
			if (r < 95) return OP_ERASE;
			if (r < 97) return OP_POP_BACK;
			return OP_POP_FRONT;
		end
		MODE_DRAIN: begin
			if (r < 25) return OP_POP_BACK;
			if (r < 50) return OP_POP_FRONT;
			if (r < 70) return OP_ERASE;
			if (r < 80) return OP_READ;
			if (r < 90) return OP_WRITE;
			if (r < 95) return OP_PUSH_BACK;
			if (r < 98) return OP_INSERT;
			if (r < 99) return OP_CLEAR;
			return OP_UNUSED_HI;
		end
		default: begin
			if (r < 90) return OP_W'($urandom_range(OP_PUSH_BACK, OP_ERASE));
			if (r < 94) return OP_CLEAR;
			return OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
		end
		endcase
	endfunction

	// Mostly legal positions, with the edges and the whole field now and then.
	function automatic logic [INDEX_W-1:0] pick_index(logic [OP_W-1:0] op);
		int top;
		int r;
		top = (op == OP_INSERT) ? book.fill : book.fill - 1;
		r   = $urandom_range(0, 9);
		if (r == 0 || top < 0) return INDEX_W'($urandom_range(0, (1 << INDEX_W) - 1));
		if (r == 1) return INDEX_W'(book.fill);
		if (r == 2) return INDEX_W'(top);
		return INDEX_W'($urandom_range(0, top));
	endfunction

	function automatic logic [VALUE_W-1:0] pick_value();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0) return '0;
		if (r == 1) return '1;
		return $urandom;
	endfunction

	// result side: accept with random stalls, in stretches calm or busy
	initial begin
		int    stall;
		int    stretch;
		bit    calm;
		string msg;
		stretch = 0;
		calm    = 1'b0;
		do @(posedge clk); while (arst_n !== 1'b1);
		forever begin
			if (stretch == 0) begin
				stretch = $urandom_range(10, 50);
				calm    = ($urandom_range(0, 3) == 0);
			end
			stretch--;
			stall = calm ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				rsp_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			msg = book.check_result(rsp_ch.data, rsp_ch.count, rsp_ch.status);
			if (msg != "") report_mismatch(msg);
		end
	end

	initial begin
		int               sent;
		int               span;
		bit               first;
		load_mode_t       mode;
		logic [OP_W-1:0]  op;
		book         = new();
		arst_n       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.op    = OP_PUSH_BACK;
		req_ch.value = '0;
		req_ch.index = '0;
		rsp_ch.ready = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue: pops ignored, indexed access out of range
		send_request(OP_POP_BACK, 32'h0000_0001, '0);
		send_request(OP_POP_FRONT, 32'h0000_0002, '0);
		send_request(OP_READ, '0, '0);
		send_request(OP_WRITE, 32'h1111_1111, '0);
		send_request(OP_ERASE, '0, '0);
		send_request(OP_INSERT, 32'h2222_2222, 7'd1);
		send_request(OP_INSERT, 32'hFFFF_FFFF, 7'd0);
		send_request(OP_PUSH_BACK, 32'h0000_0000, '1);
		// head wraps below slot zero
		send_request(OP_PUSH_FRONT, 32'hA5A5_A5A5, '0);
		send_request(OP_READ, '0, 7'd2);
		send_request(OP_READ, '0, 7'd127);
		send_request(OP_WRITE, 32'h5A5A_5A5A, 7'd1);
		// insert at the count appends at the back
		send_request(OP_INSERT, 32'h1234_5678, 7'd3);
		send_request(OP_INSERT, $urandom, 7'd1);
		send_request(OP_ERASE, '0, 7'd0);
		send_request(OP_ERASE, '0, 7'd3);
		send_request(OP_READ, '0, 7'd64);
		send_request(OP_UNUSED_LO, 32'hDEAD_BEEF, 7'd5);
		send_request(OP_UNUSED_HI, '1, '1);
		send_request(OP_POP_BACK, '0, '0);
		send_request(OP_POP_FRONT, '0, '0);
		send_request(OP_CLEAR, '1, '1);
		send_request(OP_POP_FRONT, '0, '0);
		send_request(OP_PUSH_BACK, 32'hFFFF_FFFF, '0);
		send_request(OP_POP_FRONT, '0, '0);

		// open with a long fill phase so the full ring is reached early
		sent  = 0;
		first = 1'b1;
		while (sent < RANDOM_ITEMS) begin
			mode       = first ? MODE_FILL : load_mode_t'($urandom_range(0, 2));
			span       = first ? 110 : $urandom_range(20, 80);
			first      = 1'b0;
			send_quiet = ($urandom_range(0, 3) == 0);
			repeat (span) begin
				op = pick_op(mode);
				send_request(op, pick_value(), pick_index(op));
				if (op < OP_UNUSED_LO) sent++;
			end
		end
		req_ch.valid <= 1'b0;

		while (book.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
